### hdl/tbs_pkg.sv
// Shared types and constants for the time bucket scheduler.
`timescale 1ns / 1ps
package tbs_pkg;

  localparam int unsigned RegBits = 31;
  localparam int unsigned QuoBits = 32;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_POPPED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_POP    = 1'b1
  } req_e;

  typedef enum logic {
    REG_BUCKET_WIDTH = 1'b0,
    REG_TIME_SPAN    = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_CFG_DIV,
    S_INS_DIV,
    S_INS_CHECK,
    S_INS_WRITE,
    S_POP_SCAN,
    S_POP_READ,
    S_POP_EMIT,
    S_RESULT
  } state_e;

  // Controller commands to the datapath.
  typedef struct packed {
    logic clear_step;
    logic cfg_div_start;
    logic ins_div_start;
    logic div_step;
    logic ins_index;
    logic ins_write;
    logic scan_step;
    logic pop_start;
    logic pop_read;
    logic pop_next;
    logic load_result;
    status_e res_status;
    logic    res_last;
  } dp_cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic clear_done;
    logic div_done;
    logic bucket_full;
    logic scan_hit;
    logic scan_end;
    logic pop_final;
  } dp_stat_t;

endpackage

### hdl/tbs_if.sv
// Valid/ready channel interfaces for the scheduler.
`timescale 1ns / 1ps
interface tbs_req_if #(parameter int HW = 16);
  logic          valid;
  logic          ready;
  logic          req_type;
  logic [HW-1:0] walker_handle;
  logic signed [31:0] walker_time;
  modport source (output valid, req_type, walker_handle, walker_time, input ready);
  modport sink   (input valid, req_type, walker_handle, walker_time, output ready);
endinterface

interface tbs_res_if #(parameter int HW = 16);
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic [HW-1:0] popped_handle;
  logic [6:0]    batch_count;
  logic          last;
  logic [10:0]   alive_count;
  modport source (output valid, status, popped_handle, batch_count, last, alive_count,
                  input ready);
  modport sink   (input valid, status, popped_handle, batch_count, last, alive_count,
                  output ready);
endinterface

interface tbs_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/tbs_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module tbs_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### hdl/tbs_datapath.sv
// Datapath: registers, restoring divider, bucket fill counts, store and result.
`timescale 1ns / 1ps
module tbs_datapath #(
  parameter int BucketCount    = 16,
  parameter int BucketCapacity = 64,
  parameter int HandleBits     = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tbs_pkg::dp_cmd_t      cmd_i,
  output tbs_pkg::dp_stat_t     stat_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [31:0]           cfg_data_i,
  input  logic [15:0]           in_handle_i,
  input  logic [31:0]           in_time_i,
  output logic [1:0]            res_status_o,
  output logic [15:0]           res_handle_o,
  output logic [6:0]            res_count_o,
  output logic                  res_last_o,
  output logic [10:0]           res_alive_o
);
  localparam int BIdx  = (BucketCount > 1) ? $clog2(BucketCount) : 1;
  localparam int FillW = $clog2(BucketCapacity + 1);
  localparam int CurW  = $clog2(BucketCount + 1);
  localparam int Depth = BucketCount * BucketCapacity;
  localparam int AddrW = $clog2(Depth) > 0 ? $clog2(Depth) : 1;
  localparam int AliveW = $clog2(Depth + 1);
  localparam int DivW  = tbs_pkg::QuoBits;
  localparam int RegW  = tbs_pkg::RegBits;
  // Handles are kept at the narrower of the handle width and the 16-bit field.
  localparam int StoreW = (HandleBits < 16) ? HandleBits : 16;

  logic [RegW-1:0] width_q, span_q;
  logic [CurW-1:0]  used_q, used_d;
  logic [FillW-1:0] fill_q [BucketCount];
  logic [CurW-1:0]  cursor_q;
  logic [AliveW-1:0] alive_q;
  logic [BIdx-1:0]  clr_q;
  logic [BIdx-1:0]  bidx_q;
  logic [15:0]      handle_q;

  // Restoring divider, one quotient bit per cycle.
  logic [DivW-1:0] quo_q, num_q;
  logic [tbs_pkg::RegBits:0] rem_q;
  logic [5:0]      dcnt_q;
  logic [tbs_pkg::RegBits+1:0] rem_sh, rem_sub;

  always_comb begin
    rem_sh  = {rem_q, num_q[DivW-1]};
    rem_sub = rem_sh - {2'b00, width_q};
  end

  // Pop read position.
  logic [FillW-1:0] pidx_q;
  logic [FillW-1:0] pcnt_q;

  logic [AddrW-1:0] ram_addr;
  logic [StoreW-1:0] ram_rdata, ram_wdata;
  logic [CurW-1:0] cur_b;

  assign cur_b = cursor_q;

  always_comb begin
    ram_wdata = handle_q[StoreW-1:0];
    if (cmd_i.ins_write) begin
      ram_addr = AddrW'(bidx_q * BucketCapacity + fill_q[bidx_q]);
    end else begin
      ram_addr = AddrW'(bidx_q * BucketCapacity + pidx_q);
    end
  end

  tbs_ram #(.Width(StoreW), .Depth(Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.ins_write),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // Quotient clamped to the buckets in use.
  logic [BIdx-1:0] clamp_idx;
  always_comb begin
    if (width_q == '0) begin
      clamp_idx = '0;
    end else if (quo_q >= DivW'(used_q)) begin
      clamp_idx = BIdx'(used_q - 1'b1);
    end else begin
      clamp_idx = BIdx'(quo_q);
    end
    if (width_q == '0) begin
      used_d = CurW'(1);
    end else if (quo_q >= DivW'(BucketCount)) begin
      used_d = CurW'(BucketCount);
    end else begin
      used_d = CurW'(quo_q + 1'b1);
    end
  end

  always_comb begin
    stat_o.clear_done  = (clr_q == BIdx'(BucketCount - 1));
    stat_o.div_done    = (dcnt_q == 6'd0);
    stat_o.bucket_full = (fill_q[clamp_idx] >= FillW'(BucketCapacity));
    stat_o.scan_end    = (cursor_q >= used_q);
    stat_o.scan_hit    = !stat_o.scan_end && (fill_q[BIdx'(cur_b)] != '0);
    stat_o.pop_final   = (pidx_q + 1'b1 == pcnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RegW'(1);
      span_q   <= '0;
      used_q   <= CurW'(1);
      cursor_q <= '0;
      alive_q  <= '0;
      clr_q    <= '0;
      dcnt_q   <= '0;
      num_q    <= '0;
      rem_q    <= '0;
      quo_q    <= '0;
      bidx_q   <= '0;
      handle_q <= '0;
      pidx_q   <= '0;
      pcnt_q   <= '0;
      for (int i = 0; i < BucketCount; i++) fill_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == tbs_pkg::REG_BUCKET_WIDTH) width_q <= cfg_data_i[30:0];
        else span_q <= cfg_data_i[30:0];
        clr_q    <= '0;
        cursor_q <= '0;
        alive_q  <= '0;
      end
      if (cmd_i.clear_step) begin
        fill_q[clr_q] <= '0;
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.cfg_div_start || cmd_i.ins_div_start) begin
        if (cmd_i.ins_div_start) begin
          num_q <= in_time_i[31] ? '0 : in_time_i;
        end else if (cfg_index_i == tbs_pkg::REG_TIME_SPAN) begin
          // The span register takes this word at the same edge.
          num_q <= {1'b0, cfg_data_i[RegW-1:0]};
        end else begin
          num_q <= {1'b0, span_q};
        end
        rem_q  <= '0;
        quo_q  <= '0;
        dcnt_q <= 6'(DivW);
        handle_q <= in_handle_i;
      end else if (cmd_i.div_step) begin
        num_q <= num_q << 1;
        if (!rem_sub[tbs_pkg::RegBits+1]) begin
          rem_q <= rem_sub[tbs_pkg::RegBits:0];
          quo_q <= {quo_q[DivW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[tbs_pkg::RegBits:0];
          quo_q <= {quo_q[DivW-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q - 1'b1;
      end
      if (cmd_i.clear_step && stat_o.clear_done) used_q <= used_d;
      if (cmd_i.ins_index) bidx_q <= clamp_idx;
      if (cmd_i.ins_write) begin
        fill_q[bidx_q] <= fill_q[bidx_q] + 1'b1;
        alive_q <= alive_q + 1'b1;
        if (CurW'(bidx_q) < cursor_q) cursor_q <= CurW'(bidx_q);
      end
      if (cmd_i.scan_step) cursor_q <= cursor_q + 1'b1;
      if (cmd_i.pop_start) begin
        bidx_q <= BIdx'(cur_b);
        pcnt_q <= fill_q[BIdx'(cur_b)];
        pidx_q <= '0;
        alive_q <= alive_q - AliveW'(fill_q[BIdx'(cur_b)]);
        fill_q[BIdx'(cur_b)] <= '0;
      end
      if (cmd_i.pop_next) pidx_q <= pidx_q + 1'b1;
    end
  end

  // Result register. An insert reports the count that includes its own handle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      res_status_o <= cmd_i.res_status;
      res_last_o   <= cmd_i.res_last;
      res_alive_o  <= cmd_i.ins_write ? 11'(alive_q + 1'b1) : 11'(alive_q);
      if (cmd_i.res_status == tbs_pkg::ST_POPPED) begin
        res_handle_o <= 16'(ram_rdata);
        res_count_o  <= 7'(pcnt_q);
      end else begin
        res_handle_o <= '0;
        res_count_o  <= '0;
      end
    end
  end
endmodule

### hdl/tbs_ctrl.sv
// Controller state machine sequencing clear, divide, insert and pop.
`timescale 1ns / 1ps
module tbs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  output logic               cfg_ready_o,
  input  logic               in_valid_i,
  input  logic               in_req_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tbs_pkg::dp_cmd_t   cmd_o,
  input  tbs_pkg::dp_stat_t  stat_i
);
  tbs_pkg::state_e state_q, state_d;
  logic ins_q, ins_d;
  logic full_q, full_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tbs_pkg::S_IDLE;
      ins_q   <= 1'b0;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ins_q   <= ins_d;
      full_q  <= full_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ins_d   = ins_q;
    full_d  = full_q;
    cmd_o   = '0;
    cmd_o.res_status = tbs_pkg::ST_INSERTED;
    cfg_ready_o = 1'b0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      tbs_pkg::S_IDLE: begin
        cfg_ready_o = 1'b1;
        in_ready_o  = !cfg_we_i;
        if (cfg_we_i) begin
          cmd_o.cfg_div_start = 1'b1;
          state_d = tbs_pkg::S_CFG_DIV;
        end else if (in_valid_i) begin
          if (in_req_i == tbs_pkg::REQ_INSERT) begin
            cmd_o.ins_div_start = 1'b1;
            state_d = tbs_pkg::S_INS_DIV;
          end else begin
            state_d = tbs_pkg::S_POP_SCAN;
          end
        end
      end
      tbs_pkg::S_CFG_DIV: begin
        if (stat_i.div_done) state_d = tbs_pkg::S_CLEAR;
        else cmd_o.div_step = 1'b1;
      end
      tbs_pkg::S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_done) state_d = tbs_pkg::S_IDLE;
      end
      tbs_pkg::S_INS_DIV: begin
        if (stat_i.div_done) state_d = tbs_pkg::S_INS_CHECK;
        else cmd_o.div_step = 1'b1;
      end
      tbs_pkg::S_INS_CHECK: begin
        cmd_o.ins_index = 1'b1;
        full_d  = stat_i.bucket_full;
        state_d = tbs_pkg::S_INS_WRITE;
      end
      tbs_pkg::S_INS_WRITE: begin
        cmd_o.ins_write   = !full_q;
        cmd_o.load_result = 1'b1;
        cmd_o.res_status  = full_q ? tbs_pkg::ST_DROPPED : tbs_pkg::ST_INSERTED;
        cmd_o.res_last    = 1'b1;
        ins_d   = 1'b1;
        state_d = tbs_pkg::S_RESULT;
      end
      tbs_pkg::S_POP_SCAN: begin
        if (stat_i.scan_end) begin
          cmd_o.load_result = 1'b1;
          cmd_o.res_status  = tbs_pkg::ST_EMPTY;
          cmd_o.res_last    = 1'b1;
          ins_d   = 1'b1;
          state_d = tbs_pkg::S_RESULT;
        end else if (stat_i.scan_hit) begin
          cmd_o.pop_start = 1'b1;
          state_d = tbs_pkg::S_POP_READ;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      tbs_pkg::S_POP_READ: begin
        cmd_o.pop_read = 1'b1;
        state_d = tbs_pkg::S_POP_EMIT;
      end
      tbs_pkg::S_POP_EMIT: begin
        cmd_o.load_result = 1'b1;
        cmd_o.res_status  = tbs_pkg::ST_POPPED;
        cmd_o.res_last    = stat_i.pop_final;
        ins_d   = stat_i.pop_final;
        state_d = tbs_pkg::S_RESULT;
      end
      tbs_pkg::S_RESULT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (ins_q) begin
            state_d = tbs_pkg::S_IDLE;
          end else begin
            cmd_o.pop_next = 1'b1;
            state_d = tbs_pkg::S_POP_READ;
          end
        end
      end
      default: state_d = tbs_pkg::S_IDLE;
    endcase
  end
endmodule

### hdl/time_bucket_scheduler_top.sv
// Top level of the time bucket scheduler; it works on one request word at a time.
// Insert: the time is divided by the bucket width, the bucket is checked and the handle
// stored unless it is full; the next request is taken after the result word leaves.
// Pop: buckets are scanned in turn, then each handle is read out and loaded as a result
// word, held until taken. A register write keeps the block busy through a divide and a bucket clear.
// Reset empties all buckets; the handle store is never read before it is written.
`timescale 1ns / 1ps
module time_bucket_scheduler_top #(
  parameter int BUCKET_COUNT    = 16,
  parameter int BUCKET_CAPACITY = 64,
  parameter int HANDLE_BITS     = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tbs_cfg_if.sink    cfg,
  tbs_req_if.sink    req,
  tbs_res_if.source  res
);
  tbs_pkg::dp_cmd_t  cmd;
  tbs_pkg::dp_stat_t stat;
  logic cfg_we;
  logic [15:0] res_handle;

  // Configuration words are taken only while the controller sits idle.
  assign cfg_we    = cfg.valid && cfg.ready;

  tbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_ready_o(cfg.ready),
    .in_valid_i (req.valid),
    .in_req_i   (req.req_type),
    .in_ready_o (req.ready),
    .out_valid_o(res.valid),
    .out_ready_i(res.ready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  tbs_datapath #(
    .BucketCount   (BUCKET_COUNT),
    .BucketCapacity(BUCKET_CAPACITY),
    .HandleBits    (HANDLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg.index),
    .cfg_data_i  (cfg.data),
    .in_handle_i (16'(req.walker_handle)),
    .in_time_i   (req.walker_time),
    .res_status_o(res.status),
    .res_handle_o(res_handle),
    .res_count_o (res.batch_count),
    .res_last_o  (res.last),
    .res_alive_o (res.alive_count)
  );

  assign res.popped_handle = res_handle;
endmodule

### bench/time_bucket_scheduler_top_tb.sv
// Testbench for the time bucket scheduler: directed and random requests checked
// against a behavioral scheduler model, with random idling on both channels.
`timescale 1ns / 1ps
module time_bucket_scheduler_top_tb;

  localparam int BucketCount = 16;
  localparam int BucketCap   = 64;
  localparam int HandleBits  = 16;
  localparam int StallLimit  = 20000;
  localparam int DrainCycles = 200;

  // One result word as the scheduler emits it.
  typedef struct packed {
    tbs_pkg::status_e status;
    logic [15:0] handle;
    logic [6:0]  batch;
    logic        last;
    logic [10:0] alive;
  } sched_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tbs_cfg_if              cfg ();
  tbs_req_if #(HandleBits) req ();
  tbs_res_if #(HandleBits) res ();

  time_bucket_scheduler_top #(
    .BUCKET_COUNT   (BucketCount),
    .BUCKET_CAPACITY(BucketCap),
    .HANDLE_BITS    (HandleBits)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg   (cfg),
    .req   (req),
    .res   (res)
  );

  always #10 clk_i = ~clk_i;

  // Model of the scheduler state, updated as each request word is accepted.
  logic [30:0] width_q, span_q;
  int          buckets_in_use;
  logic [15:0] store_q [BucketCount][BucketCap];
  int          fill_q [BucketCount];
  int          cursor_q;
  int          alive_q;
  sched_word_t expected_words [$];

  int  error_count = 0;
  int  idle_cycles = 0;
  bit  quiet_mode;     // No idling at all in the last part of the run.
  bit  sink_stalls;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic void model_clear();
    int n;
    if (width_q == 0) n = 1;
    else n = int'(span_q / width_q) + 1;
    buckets_in_use = (n > BucketCount || n < 1) ? BucketCount : n;
    if (width_q != 0 && span_q / width_q >= BucketCount) buckets_in_use = BucketCount;
    foreach (fill_q[i]) fill_q[i] = 0;
    cursor_q = 0;
    alive_q  = 0;
  endfunction

  // Works out the result words one request causes and updates the model.
  function automatic void predict_request(input tbs_pkg::req_e kind, input logic [15:0] h,
                                          input logic signed [31:0] t);
    sched_word_t w;
    logic [31:0] tt;
    longint unsigned slot;
    int b, n;
    w = '0;
    w.last = 1'b1;
    if (kind == tbs_pkg::REQ_INSERT) begin
      tt = (t < 0) ? 32'd0 : t;
      slot = (width_q == 0) ? 0 : longint'(tt) / longint'(width_q);
      b = (slot >= buckets_in_use) ? buckets_in_use - 1 : int'(slot);
      if (fill_q[b] >= BucketCap) begin
        w.status = tbs_pkg::ST_DROPPED;
      end else begin
        store_q[b][fill_q[b]] = h;
        fill_q[b]++;
        if (b < cursor_q) cursor_q = b;
        alive_q++;
        w.status = tbs_pkg::ST_INSERTED;
      end
      w.alive = 11'(alive_q);
      expected_words.push_back(w);
    end else begin
      while (cursor_q < buckets_in_use && fill_q[cursor_q] == 0) cursor_q++;
      if (cursor_q >= buckets_in_use) begin
        w.status = tbs_pkg::ST_EMPTY;
        w.alive  = 11'(alive_q);
        expected_words.push_back(w);
      end else begin
        n = fill_q[cursor_q];
        alive_q -= n;
        fill_q[cursor_q] = 0;
        for (int i = 0; i < n; i++) begin
          w.status = tbs_pkg::ST_POPPED;
          w.handle = store_q[cursor_q][i];
          w.batch  = 7'(n);
          w.last   = (i == n - 1);
          w.alive  = 11'(alive_q);
          expected_words.push_back(w);
        end
      end
    end
  endfunction

  task automatic maybe_idle();
    if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // Sends one request word and updates the model when it is accepted. Valid stays
  // up after the handshake only until the next word or a wait replaces it.
  task automatic send_request(input tbs_pkg::req_e kind, input logic [15:0] h,
                              input logic signed [31:0] t);
    maybe_idle();
    req.valid         <= 1'b1;
    req.req_type      <= kind;
    req.walker_handle <= h;
    req.walker_time   <= t;
    do @(posedge clk_i); while (!req.ready);
    predict_request(kind, h, t);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  // Register writes happen only with nothing in flight.
  task automatic write_register(input tbs_pkg::reg_e idx, input logic [31:0] value);
    wait_drained();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == tbs_pkg::REG_BUCKET_WIDTH) width_q = value[30:0];
    else span_q = value[30:0];
    model_clear();
  endtask

  function automatic logic signed [31:0] rand_time(input int hi);
    return (hi <= 0) ? 32'sd0 : $urandom_range(0, hi);
  endfunction

  // Result side: random stalls and a field-by-field compare.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word status", res.status, -1);
        end else begin
          sched_word_t e;
          e = expected_words.pop_front();
          if (res.status != e.status) report_mismatch("status", res.status, e.status);
          if (res.popped_handle != e.handle)
            report_mismatch("popped_handle", res.popped_handle, e.handle);
          if (res.batch_count != e.batch)
            report_mismatch("batch_count", res.batch_count, e.batch);
          if (res.last != e.last) report_mismatch("last", res.last, e.last);
          if (res.alive_count != e.alive)
            report_mismatch("alive_count", res.alive_count, e.alive);
        end
      end
      if (quiet_mode) begin
        res.ready <= 1'b1;
      end else if (sink_stalls) begin
        if (idle_cycles > 0) begin
          idle_cycles <= idle_cycles - 1;
          res.ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
          idle_cycles <= $urandom_range(1, 19);
          res.ready <= 1'b0;
        end else begin
          res.ready <= 1'b1;
        end
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run if nothing moves on any channel for too long.
  int stall_count = 0;
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
    if (stall_count >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Directed: field extremes, negative time, a pop on an empty scheduler.
  task automatic test_basic_extremes();
    send_request(tbs_pkg::REQ_POP, 16'hFFFF, -32'sd1);
    send_request(tbs_pkg::REQ_INSERT, 16'hFFFF, 32'h7FFF_FFFF);
    send_request(tbs_pkg::REQ_INSERT, 16'h0000, 32'sh8000_0000);
    send_request(tbs_pkg::REQ_INSERT, 16'hA5A5, -32'sd5);
    send_request(tbs_pkg::REQ_POP, 16'h0, 0);
    send_request(tbs_pkg::REQ_POP, 16'h0, 0);
  endtask

  // Directed: a bucket filled past its capacity, then drained in one batch.
  task automatic test_full_bucket();
    write_register(tbs_pkg::REG_BUCKET_WIDTH, 32'd10);
    write_register(tbs_pkg::REG_TIME_SPAN, 32'd159);
    for (int i = 0; i < BucketCap + 2; i++) send_request(tbs_pkg::REQ_INSERT, 16'(i), 35);
    send_request(tbs_pkg::REQ_INSERT, 16'h1234, 5);
    send_request(tbs_pkg::REQ_POP, 16'h0, 0);
    send_request(tbs_pkg::REQ_POP, 16'h0, 0);
    send_request(tbs_pkg::REQ_POP, 16'h0, 0);
  endtask

  // Directed: zero width, a huge span that saturates the bucket count, and
  // the register bit above the used range.
  task automatic test_width_span_extremes();
    write_register(tbs_pkg::REG_BUCKET_WIDTH, 32'd0);
    send_request(tbs_pkg::REQ_INSERT, 16'h0001, 32'h7FFF_FFFF);
    send_request(tbs_pkg::REQ_INSERT, 16'h0002, 0);
    send_request(tbs_pkg::REQ_POP, 16'h0, 0);
    write_register(tbs_pkg::REG_BUCKET_WIDTH, 32'hFFFF_FFFF);
    write_register(tbs_pkg::REG_TIME_SPAN, 32'hFFFF_FFFF);
    send_request(tbs_pkg::REQ_INSERT, 16'h0003, 32'h7FFF_FFFF);
    send_request(tbs_pkg::REQ_POP, 16'h0, 0);
    write_register(tbs_pkg::REG_BUCKET_WIDTH, 32'd1);
    send_request(tbs_pkg::REQ_INSERT, 16'h0004, 32'h7FFF_FFFF);
    send_request(tbs_pkg::REQ_INSERT, 16'h0005, 3);
    send_request(tbs_pkg::REQ_POP, 16'h0, 0);
    send_request(tbs_pkg::REQ_POP, 16'h0, 0);
  endtask

  // Random: insert-heavy runs broken by pops under several settings, so the
  // cursor gets pulled back and buckets fill up now and then.
  task automatic test_random_traffic(input int count, input logic [31:0] bw,
                                     input logic [31:0] sp);
    int hi;
    write_register(tbs_pkg::REG_BUCKET_WIDTH, bw);
    write_register(tbs_pkg::REG_TIME_SPAN, sp);
    hi = (sp[30:0] > 200000) ? 200000 : int'(sp[30:0]) + 8;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_request(tbs_pkg::REQ_POP, 16'($urandom), $urandom);
      else if ($urandom_range(0, 7) == 0)
        send_request(tbs_pkg::REQ_INSERT, 16'($urandom), $urandom);
      else
        send_request(tbs_pkg::REQ_INSERT, 16'($urandom), rand_time(hi));
    end
    send_request(tbs_pkg::REQ_POP, 16'h0, 0);
  endtask

  initial begin
    quiet_mode  = 1'b0;
    sink_stalls = 1'b1;
    width_q = 31'd1;
    span_q  = 31'd0;
    model_clear();
    cfg.valid = 1'b0;
    cfg.index = 1'b0;
    cfg.data  = '0;
    req.valid = 1'b0;
    req.req_type = 1'b0;
    req.walker_handle = '0;
    req.walker_time = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_extremes();
    test_full_bucket();
    test_width_span_extremes();
    test_random_traffic(110, 32'd7, 32'd100);
    // The sender holds off here until every expected word has come back.
    wait_drained();
    test_random_traffic(110, 32'd1000, 32'd100000);
    test_random_traffic(70, 32'd3, 32'd0);
    quiet_mode = 1'b1;
    test_random_traffic(110, 32'd2, 32'd31);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
